[rtl/tokz_pkg.sv]
// tokz_pkg: shared types and constants of the source text tokenizer.
// Result record, step bundle, token kind codes and character codes.
// No dependencies.
`timescale 1ns / 1ps

package tokz_pkg;

  localparam int unsigned PosW  = 16;
  localparam int unsigned HeadW = 64;
  localparam int unsigned LenOutW = 8;

  typedef enum logic [2:0] {
    KIND_AT       = 3'd0,
    KIND_KEYWORD  = 3'd1,
    KIND_IDENT    = 3'd2,
    KIND_STRING   = 3'd3,
    KIND_OPERATOR = 3'd4,
    KIND_EOF      = 3'd5
  } tokz_kind_e;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // keyword text, first byte lowest
  localparam logic [HeadW-1:0] KW_FUNC = 64'h0000_0000_636E_7566;
  localparam logic [HeadW-1:0] KW_VAR  = 64'h0000_0000_0072_6176;
  localparam logic [HeadW-1:0] KW_FOR  = 64'h0000_0000_0072_6F66;
  localparam logic [HeadW-1:0] KW_IN   = 64'h0000_0000_0000_6E69;

  localparam logic [PosW-1:0] POS_MAX = '1;
  localparam logic [PosW-1:0] POS_ONE = PosW'(1);

  typedef struct packed {
    tokz_kind_e          kind;
    logic [PosW-1:0]     line;
    logic [PosW-1:0]     column;
    logic [LenOutW-1:0]  length;
    logic [HeadW-1:0]    head;
    logic                last;
  } tokz_result_t;

  // results of one byte: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0]   count;
    tokz_result_t res0;
    tokz_result_t res1;
  } tokz_step_t;

endpackage

[rtl/tokz_scan.sv]
// tokz_scan: tokenizer state and the per-byte scan step.
// Depends on tokz_pkg.
`timescale 1ns / 1ps

module tokz_scan import tokz_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = 255,
  parameter int unsigned HEAD_BYTES    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_input_i,
  output tokz_step_t step_o
);

  localparam int unsigned LenW = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_STRING = 2'd2
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  line_q, line_d, col_q, col_d;
  logic [PosW-1:0]  sline_q, sline_d, scol_q, scol_d;
  logic [LenW-1:0]  tlen_q, tlen_d;
  logic [HeadW-1:0] head_q, head_d;

  logic             is_end, is_alpha, is_digit, is_space, is_word;
  logic             pend_v, oth_v, classify;
  logic [PosW-1:0]  line_adv, col_adv;
  tokz_result_t     pend_r, oth_r;

  function automatic logic [LenOutW-1:0] sat_len(input logic [LenW-1:0] len);
    sat_len = (32'(len) > 32'd255) ? 8'hFF : LenOutW'(len);
  endfunction

  // -- byte classes and position advance
  always_comb begin
    is_end   = end_of_input_i || (char_byte_i == CH_NUL);
    is_alpha = ((char_byte_i >= 8'h61) && (char_byte_i <= 8'h7A)) ||
               ((char_byte_i >= 8'h41) && (char_byte_i <= 8'h5A));
    is_digit = (char_byte_i >= 8'h30) && (char_byte_i <= 8'h39);
    is_space = (char_byte_i == CH_SPACE) ||
               ((char_byte_i >= CH_TAB) && (char_byte_i <= CH_CR));
    is_word  = is_alpha || is_digit || (char_byte_i == CH_UNDERSCORE);
    if (char_byte_i == CH_NEWLINE) begin
      line_adv = (line_q < POS_MAX) ? line_q + POS_ONE : line_q;
      col_adv  = POS_ONE;
    end else begin
      line_adv = line_q;
      col_adv  = (col_q < POS_MAX) ? col_q + POS_ONE : col_q;
    end
  end

  // -- pending token as it would be emitted now
  always_comb begin
    pend_r.kind = KIND_IDENT;
    if (mode_q == MODE_STRING) begin
      pend_r.kind = KIND_STRING;
    end else if ((tlen_q == LenW'(4) && head_q == KW_FUNC) ||
                 (tlen_q == LenW'(3) && head_q == KW_VAR) ||
                 (tlen_q == LenW'(3) && head_q == KW_FOR) ||
                 (tlen_q == LenW'(2) && head_q == KW_IN)) begin
      pend_r.kind = KIND_KEYWORD;
    end
    pend_r.line   = sline_q;
    pend_r.column = scol_q;
    pend_r.length = sat_len(tlen_q);
    pend_r.head   = head_q;
    pend_r.last   = 1'b0;
  end

  // -- scan step
  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    tlen_d   = tlen_q;
    head_d   = head_q;
    pend_v   = 1'b0;
    oth_v    = 1'b0;
    classify = 1'b0;
    oth_r    = '{kind: KIND_EOF, line: line_q, column: col_q, length: '0,
                 head: '0, last: 1'b0};

    if (is_end) begin
      pend_v  = (mode_q != MODE_IDLE);
      oth_v   = 1'b1;
      mode_d  = MODE_IDLE;
      line_d  = POS_ONE;
      col_d   = POS_ONE;
      sline_d = POS_ONE;
      scol_d  = POS_ONE;
      tlen_d  = '0;
      head_d  = '0;
    end else begin
      case (mode_q)
        MODE_STRING: begin
          line_d = line_adv;
          col_d  = col_adv;
          if (char_byte_i == CH_QUOTE) begin
            pend_v = 1'b1;
            mode_d = MODE_IDLE;
          end else if (tlen_q < LenW'(MAX_TOKEN_LEN)) begin
            if (tlen_q < LenW'(HEAD_BYTES)) begin
              head_d = head_q | (HeadW'(char_byte_i) << {tlen_q[2:0], 3'b000});
            end
            tlen_d = tlen_q + LenW'(1);
          end
        end
        MODE_IDENT: begin
          if (is_word) begin
            line_d = line_adv;
            col_d  = col_adv;
            if (tlen_q < LenW'(MAX_TOKEN_LEN)) begin
              if (tlen_q < LenW'(HEAD_BYTES)) begin
                head_d = head_q | (HeadW'(char_byte_i) << {tlen_q[2:0], 3'b000});
              end
              tlen_d = tlen_q + LenW'(1);
            end
          end else begin
            pend_v   = 1'b1;
            mode_d   = MODE_IDLE;
            classify = 1'b1;
          end
        end
        default: classify = 1'b1;
      endcase

      if (classify) begin
        line_d = line_adv;
        col_d  = col_adv;
        if (is_space) begin
          // skipped
        end else if (char_byte_i == CH_QUOTE) begin
          mode_d  = MODE_STRING;
          sline_d = line_q;
          scol_d  = col_q;
          tlen_d  = '0;
          head_d  = '0;
        end else if (is_alpha || (char_byte_i == CH_UNDERSCORE)) begin
          mode_d  = MODE_IDENT;
          sline_d = line_q;
          scol_d  = col_q;
          tlen_d  = LenW'(1);
          head_d  = HeadW'(char_byte_i);
        end else begin
          oth_v       = 1'b1;
          oth_r.kind  = (char_byte_i == CH_AT) ? KIND_AT : KIND_OPERATOR;
          oth_r.length = LenOutW'(1);
          oth_r.head  = HeadW'(char_byte_i);
        end
      end
    end

    // pack results in emission order
    step_o.count = 2'(pend_v) + 2'(oth_v);
    step_o.res0  = pend_v ? pend_r : oth_r;
    step_o.res1  = oth_r;
    step_o.res0.last = !(pend_v && oth_v);
    step_o.res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      sline_q <= POS_ONE;
      scol_q  <= POS_ONE;
      tlen_q  <= '0;
      head_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      tlen_q  <= tlen_d;
      head_q  <= head_d;
    end
  end

endmodule

[rtl/tokz_fifo.sv]
// tokz_fifo: four-entry result queue, takes up to two results a cycle.
// Depends on tokz_pkg.
`timescale 1ns / 1ps

module tokz_fifo import tokz_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  tokz_step_t   step_i,
  output logic         space_o,
  output tokz_result_t head_o,
  output logic         valid_o,
  input  logic         ready_i
);

  tokz_result_t mem_q [4];
  logic [1:0]   rd_q, rd_d, wr_q, wr_d;
  logic [2:0]   cnt_q, cnt_d;
  logic [1:0]   n_push;
  logic         pop;

  always_comb begin
    n_push  = push_i ? step_i.count : 2'd0;
    pop     = valid_o && ready_i;
    rd_d    = rd_q + 2'(pop);
    wr_d    = wr_q + n_push;
    cnt_d   = cnt_q + 3'(n_push) - 3'(pop);
    valid_o = (cnt_q != 3'd0);
    space_o = (cnt_q <= 3'd2);
    head_o  = mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= step_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + 2'd1] <= step_i.res1;
    end
  end

endmodule

[rtl/source_text_tokenizer_unit.sv]
// source_text_tokenizer_unit: byte-stream tokenizer, top level.
// Depends on tokz_pkg, tokz_scan and tokz_fifo.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | in_valid_i / in_ready_o   | char_byte_i, end_of_input_i
//  out     | output    | out_valid_o / out_ready_i | token_kind_o .. text_head_o,
//          |           |                           | is_last_o
//
// One byte request a cycle while the queue has room: a byte is held in the input
// register, the scan step runs on it and its results (none, one or two) go into a
// four-entry result queue. The queue drains one result a cycle while the output
// is ready, so bytes that yield two results cap the rate at the output side.
// Reset puts the scanner at line 1, column 1 with no token pending and
// empties the queue. A stalled output holds the queue; the input register
// moves on only while the queue has room for two results.

module source_text_tokenizer_unit import tokz_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = 255,
  parameter int unsigned HEAD_BYTES    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_byte_i,
  input  logic             end_of_input_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       token_kind_o,
  output logic [PosW-1:0]  start_line_o,
  output logic [PosW-1:0]  start_column_o,
  output logic [7:0]       text_length_o,
  output logic [HeadW-1:0] text_head_o,
  output logic             is_last_o
);

  logic         inq_valid_q, inq_valid_d;
  logic [7:0]   inq_char_q;
  logic         inq_end_q;
  logic         space, advance;
  tokz_step_t   step;
  tokz_result_t head;

  // the registered byte is scanned once the queue can take both results
  always_comb begin
    advance     = inq_valid_q && space;
    in_ready_o  = !inq_valid_q || advance;
    inq_valid_d = in_ready_o ? in_valid_i : inq_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_char_q <= char_byte_i;
      inq_end_q  <= end_of_input_i;
    end
  end

  tokz_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .HEAD_BYTES    (HEAD_BYTES)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .char_byte_i    (inq_char_q),
    .end_of_input_i (inq_end_q),
    .step_o         (step)
  );

  tokz_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance),
    .step_i  (step),
    .space_o (space),
    .head_o  (head),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i)
  );

  assign token_kind_o   = head.kind;
  assign start_line_o   = head.line;
  assign start_column_o = head.column;
  assign text_length_o  = head.length;
  assign text_head_o    = head.head;
  assign is_last_o      = head.last;

endmodule
